FILE: src/ecpad_pkg.sv
// ----------------------------------------------------------------------------
// ecpad_pkg
// Shared types, constants and the microprogram for the affine point
// add/double engine.
// ----------------------------------------------------------------------------
package ecpad_pkg;

   // Field width and port layout.
   localparam int FIELD_BITS_DEF = 64;
   localparam int DATA_BITS      = 64;
   localparam int REQ_TDATA_BITS = 264;
   localparam int RSP_TDATA_BITS = 136;
   localparam int PC_BITS        = 5;

   // Register reset values.
   localparam logic [DATA_BITS-1:0] MODULUS_RESET = 64'd7;
   localparam logic [DATA_BITS-1:0] CURVE_A_RESET = 64'd0;

   // Configuration register indexes.
   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_CURVE_A = 1'b1;

   // Operation codes carried in tuser.
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_DOUBLE = 1'b1;

   // Microprogram entry points.
   localparam logic [PC_BITS-1:0] PC_START = 5'd0;
   localparam logic [PC_BITS-1:0] PC_DBL   = 5'd6;
   localparam logic [PC_BITS-1:0] PC_ADD   = 5'd11;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [3:0] {
      R_X1  = 4'd0,
      R_Y1  = 4'd1,
      R_X2  = 4'd2,
      R_Y2  = 4'd3,
      R_A   = 4'd4,
      R_NUM = 4'd5,
      R_DEN = 4'd6,
      R_L   = 4'd7,
      R_T   = 4'd8
   } reg_sel_type;

   typedef enum logic [2:0] {
      K_RED  = 3'd0,
      K_CASE = 3'd1,
      K_MUL  = 3'd2,
      K_ADD  = 3'd3,
      K_SUB  = 3'd4,
      K_INV  = 3'd5,
      K_DONE = 3'd6
   } ukind_type;

   typedef struct packed {
      ukind_type            kind;
      reg_sel_type          src_a;
      reg_sel_type          src_b;
      reg_sel_type          dst;
      logic [PC_BITS-1:0]   next;
   } uinstr_type;

   function automatic uinstr_type mk(ukind_type k, reg_sel_type a, reg_sel_type b,
                                     reg_sel_type d, logic [PC_BITS-1:0] n);
      uinstr_type u;
      u.kind  = k;
      u.src_a = a;
      u.src_b = b;
      u.dst   = d;
      u.next  = n;
      return u;
   endfunction

   // Microprogram: reduce operands, classify, build slope fraction,
   // invert the denominator, then form the new point in T (x) and NUM (y).
   function automatic uinstr_type ucode(logic [PC_BITS-1:0] pc);
      uinstr_type u;
      case (pc)
         5'd0:    u = mk(K_RED,  R_X1,  R_X1,  R_X1,  5'd1);
         5'd1:    u = mk(K_RED,  R_Y1,  R_Y1,  R_Y1,  5'd2);
         5'd2:    u = mk(K_RED,  R_X2,  R_X2,  R_X2,  5'd3);
         5'd3:    u = mk(K_RED,  R_Y2,  R_Y2,  R_Y2,  5'd4);
         5'd4:    u = mk(K_RED,  R_A,   R_A,   R_A,   5'd5);
         5'd5:    u = mk(K_CASE, R_X1,  R_X1,  R_X1,  5'd5);
         // Doubling: num = 3x^2 + a, den = 2y.
         5'd6:    u = mk(K_MUL,  R_X1,  R_X1,  R_NUM, 5'd7);
         5'd7:    u = mk(K_ADD,  R_NUM, R_NUM, R_T,   5'd8);
         5'd8:    u = mk(K_ADD,  R_T,   R_NUM, R_NUM, 5'd9);
         5'd9:    u = mk(K_ADD,  R_NUM, R_A,   R_NUM, 5'd10);
         5'd10:   u = mk(K_ADD,  R_Y1,  R_Y1,  R_DEN, 5'd13);
         // Addition: num = y2 - y1, den = x2 - x1.
         5'd11:   u = mk(K_SUB,  R_X2,  R_X1,  R_DEN, 5'd12);
         5'd12:   u = mk(K_SUB,  R_Y2,  R_Y1,  R_NUM, 5'd13);
         5'd13:   u = mk(K_INV,  R_DEN, R_DEN, R_DEN, 5'd14);
         // Finish: l = num/den, x3 = l^2 - x1 - x2, y3 = l(x1 - x3) - y1.
         5'd14:   u = mk(K_MUL,  R_NUM, R_DEN, R_L,   5'd15);
         5'd15:   u = mk(K_MUL,  R_L,   R_L,   R_T,   5'd16);
         5'd16:   u = mk(K_SUB,  R_T,   R_X1,  R_T,   5'd17);
         5'd17:   u = mk(K_SUB,  R_T,   R_X2,  R_T,   5'd18);
         5'd18:   u = mk(K_SUB,  R_X1,  R_T,   R_NUM, 5'd19);
         5'd19:   u = mk(K_MUL,  R_L,   R_NUM, R_NUM, 5'd20);
         5'd20:   u = mk(K_SUB,  R_NUM, R_Y1,  R_NUM, 5'd21);
         default: u = mk(K_DONE, R_T,   R_NUM, R_T,   5'd21);
      endcase
      return u;
   endfunction

endpackage

FILE: src/ecpad_modalu.sv
// ----------------------------------------------------------------------------
// ecpad_modalu
// Modular adder/subtractor shared by the add, subtract, multiply and Euclid update steps.
// ----------------------------------------------------------------------------
module ecpad_modalu import ecpad_pkg::*; #(
   parameter int FIELD_BITS = FIELD_BITS_DEF
) (
   input  alu_op_type             op,
   input  logic [FIELD_BITS-1:0]  a,
   input  logic [FIELD_BITS-1:0]  b,
   input  logic [FIELD_BITS-1:0]  m,
   output logic [FIELD_BITS-1:0]  r
);

   logic [FIELD_BITS:0] sum;
   logic [FIELD_BITS:0] sum_red;
   logic [FIELD_BITS:0] diff;
   logic [FIELD_BITS:0] diff_fix;

   // Both operands are below m, so one correction brings the value back.
   always_comb begin
      sum      = {1'b0, a} + {1'b0, b};
      sum_red  = sum - {1'b0, m};
      diff     = {1'b0, a} - {1'b0, b};
      diff_fix = diff + {1'b0, m};
      if (op == ALU_SUB) begin
         r = diff[FIELD_BITS] ? diff_fix[FIELD_BITS-1:0] : diff[FIELD_BITS-1:0];
      end else begin
         r = (sum >= {1'b0, m}) ? sum_red[FIELD_BITS-1:0] : sum[FIELD_BITS-1:0];
      end
   end

endmodule

FILE: src/ecpad_divider.sv
// ----------------------------------------------------------------------------
// ecpad_divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ecpad_divider #(
   parameter int FIELD_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [FIELD_BITS-1:0]  dividend,
   input  logic [FIELD_BITS-1:0]  divisor,
   output logic                   done,
   output logic [FIELD_BITS-1:0]  quotient,
   output logic [FIELD_BITS-1:0]  remainder
);

   localparam int CNT_BITS = $clog2(FIELD_BITS);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [FIELD_BITS-1:0]  quo_ff, quo_in;
   logic [FIELD_BITS-1:0]  rem_ff, rem_in;
   logic [FIELD_BITS-1:0]  dvs_ff, dvs_in;
   logic [FIELD_BITS:0]    trial;
   logic [FIELD_BITS:0]    trial_sub;
   logic                   fits;

   // One step: bring down the next dividend bit and try the subtraction.
   always_comb begin
      trial     = {rem_ff, quo_ff[FIELD_BITS-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      fits      = trial >= {1'b0, dvs_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[FIELD_BITS-2:0], fits};
         rem_in = fits ? trial_sub[FIELD_BITS-1:0] : trial[FIELD_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(FIELD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/ec_affine_point_add_double_top.sv
// ----------------------------------------------------------------------------
// ec_affine_point_add_double_top
// Affine point addition and doubling on a short Weierstrass curve over a
// prime field, run by a microprogrammed sequencer around one modular adder.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req_     in         tuser: op; tdata: first point, second point
//  rsp_     out        tdata: result_x, result_y, result_is_inf
//  csr_     in         write of modulus (index 0) or curve_a (index 1)
//
//  After acceptance an item's operands are reduced and classified; items
//  that need no slope are then offered, the others first build and invert
//  the slope denominator (extended Euclid) and then form the new point.
//  Run time is set by the bit-serial divider, which reduces operands and
//  runs the Euclid steps, and by the double-and-add multiplier, which runs
//  on the single modular adder.
//  Reset is synchronous; it empties the engine and restores both registers.
//  req_tready is high only while idle; a result is held until taken.
// ----------------------------------------------------------------------------
module ec_affine_point_add_double_top import ecpad_pkg::*; #(
   parameter int FIELD_BITS = FIELD_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // first_x, first_y, first_is_inf, second_x, second_y, second_is_inf, zero pad
   input  logic [REQ_TDATA_BITS-1:0]  req_tdata,
   // op
   input  logic [0:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // result_x, result_y, result_is_inf, zero pad
   output logic [RSP_TDATA_BITS-1:0]  rsp_tdata,
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [DATA_BITS-1:0]       csr_wdata
);

   localparam int W        = FIELD_BITS;
   localparam int CNT_BITS = $clog2(FIELD_BITS);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_FETCH   = 8'b0000_0010,
      ST_RED     = 8'b0000_0100,
      ST_MUL     = 8'b0000_1000,
      ST_EUC_CHK = 8'b0001_0000,
      ST_EUC_DIV = 8'b0010_0000,
      ST_EUC_UPD = 8'b0100_0000,
      ST_OUT     = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [PC_BITS-1:0]   pc_ff, pc_in;
   uinstr_type           uop;

   logic [W-1:0]  modulus_ff, curve_a_ff;
   logic [W-1:0]  x1_ff, y1_ff, x2_ff, y2_ff, a_ff, num_ff, den_ff, l_ff, t_ff;
   logic          op_ff, inf1_ff, inf2_ff;
   logic [W-1:0]  r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [W-1:0]  acc_ff, acc_in, mulb_ff, mulb_in;
   logic [CNT_BITS-1:0] mcnt_ff, mcnt_in;
   logic          phase_ff, phase_in, euc_ff, euc_in;
   logic [W-1:0]  out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic          out_inf_ff, out_inf_in;

   logic          load_item;
   logic          wr_en;
   reg_sel_type   wr_sel;
   logic [W-1:0]  wr_data;
   logic [W-1:0]  rd_a, rd_b, mcand;

   alu_op_type    alu_op;
   logic [W-1:0]  alu_a, alu_b, alu_r;

   logic          div_start, div_done;
   logic [W-1:0]  div_dividend, div_divisor, div_quo, div_rem;

   assign uop = ucode(pc_ff);

   // Operand read selection.
   always_comb begin
      unique case (uop.src_a)
         R_X1:    rd_a = x1_ff;
         R_Y1:    rd_a = y1_ff;
         R_X2:    rd_a = x2_ff;
         R_Y2:    rd_a = y2_ff;
         R_A:     rd_a = a_ff;
         R_NUM:   rd_a = num_ff;
         R_DEN:   rd_a = den_ff;
         R_L:     rd_a = l_ff;
         R_T:     rd_a = t_ff;
         default: rd_a = '0;
      endcase
      unique case (uop.src_b)
         R_X1:    rd_b = x1_ff;
         R_Y1:    rd_b = y1_ff;
         R_X2:    rd_b = x2_ff;
         R_Y2:    rd_b = y2_ff;
         R_A:     rd_b = a_ff;
         R_NUM:   rd_b = num_ff;
         R_DEN:   rd_b = den_ff;
         R_L:     rd_b = l_ff;
         R_T:     rd_b = t_ff;
         default: rd_b = '0;
      endcase
   end

   assign mcand = euc_ff ? t1_ff : rd_a;

   // The shared modular adder takes its operands from the active state.
   always_comb begin
      alu_op = ALU_ADD;
      alu_a  = rd_a;
      alu_b  = rd_b;
      if (state_ff == ST_MUL) begin
         alu_a = acc_ff;
         alu_b = phase_ff ? mcand : acc_ff;
      end else if (state_ff == ST_EUC_UPD) begin
         alu_op = ALU_SUB;
         alu_a  = t0_ff;
         alu_b  = acc_ff;
      end else if (uop.kind == K_SUB) begin
         alu_op = ALU_SUB;
      end
   end

   ecpad_modalu #(.FIELD_BITS(W)) u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .m  (modulus_ff),
      .r  (alu_r)
   );

   // The divider reduces operands by the modulus and runs the Euclid steps.
   always_comb begin
      if (state_ff == ST_EUC_CHK) begin
         div_dividend = r0_ff;
         div_divisor  = r1_ff;
      end else begin
         div_dividend = rd_a;
         div_divisor  = modulus_ff;
      end
   end

   ecpad_divider #(.FIELD_BITS(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      load_item  = 1'b0;
      wr_en      = 1'b0;
      wr_sel     = uop.dst;
      wr_data    = alu_r;
      div_start  = 1'b0;
      r0_in      = r0_ff;
      r1_in      = r1_ff;
      t0_in      = t0_ff;
      t1_in      = t1_ff;
      acc_in     = acc_ff;
      mulb_in    = mulb_ff;
      mcnt_in    = mcnt_ff;
      phase_in   = phase_ff;
      euc_in     = euc_ff;
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      out_inf_in = out_inf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               load_item = 1'b1;
               pc_in     = PC_START;
               if (modulus_ff < W'(2)) begin
                  out_x_in   = '0;
                  out_y_in   = W'(1);
                  out_inf_in = 1'b1;
                  state_in   = ST_OUT;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end

         ST_FETCH: begin
            unique case (uop.kind) inside
               K_RED: begin
                  div_start = 1'b1;
                  state_in  = ST_RED;
               end
               K_CASE: begin
                  // Pick the result directly, or the doubling or chord path.
                  out_x_in   = '0;
                  out_y_in   = W'(1);
                  out_inf_in = 1'b1;
                  state_in   = ST_OUT;
                  if (op_ff == OP_DOUBLE) begin
                     if (!inf1_ff && y1_ff != '0) begin
                        wr_en    = 1'b1;
                        wr_sel   = R_X2;
                        wr_data  = x1_ff;
                        pc_in    = PC_DBL;
                        state_in = ST_FETCH;
                     end
                  end else if (inf1_ff && inf2_ff) begin
                     out_inf_in = 1'b1;
                  end else if (inf1_ff) begin
                     out_x_in   = x2_ff;
                     out_y_in   = y2_ff;
                     out_inf_in = 1'b0;
                  end else if (inf2_ff) begin
                     out_x_in   = x1_ff;
                     out_y_in   = y1_ff;
                     out_inf_in = 1'b0;
                  end else if (x1_ff == x2_ff) begin
                     if (y1_ff == y2_ff && y1_ff != '0) begin
                        pc_in    = PC_DBL;
                        state_in = ST_FETCH;
                     end
                  end else begin
                     pc_in    = PC_ADD;
                     state_in = ST_FETCH;
                  end
               end
               K_MUL: begin
                  acc_in   = '0;
                  mulb_in  = rd_b;
                  mcnt_in  = '0;
                  phase_in = 1'b0;
                  euc_in   = 1'b0;
                  state_in = ST_MUL;
               end
               K_ADD, K_SUB: begin
                  wr_en = 1'b1;
                  pc_in = uop.next;
               end
               K_INV: begin
                  r0_in    = modulus_ff;
                  r1_in    = rd_a;
                  t0_in    = '0;
                  t1_in    = W'(1);
                  state_in = ST_EUC_CHK;
               end
               default: begin
                  out_x_in   = t_ff;
                  out_y_in   = num_ff;
                  out_inf_in = 1'b0;
                  state_in   = ST_OUT;
               end
            endcase
         end

         ST_RED: begin
            if (div_done) begin
               wr_en    = 1'b1;
               wr_data  = div_rem;
               pc_in    = uop.next;
               state_in = ST_FETCH;
            end
         end

         // Double-and-add, most significant multiplier bit first: a doubling phase, then a conditional add.
         ST_MUL: begin
            if (!phase_ff) begin
               acc_in   = alu_r;
               phase_in = 1'b1;
            end else begin
               if (mulb_ff[W-1]) begin
                  acc_in = alu_r;
               end
               mulb_in  = {mulb_ff[W-2:0], 1'b0};
               mcnt_in  = mcnt_ff + 1'b1;
               phase_in = 1'b0;
               if (mcnt_ff == CNT_BITS'(W - 1)) begin
                  if (euc_ff) begin
                     state_in = ST_EUC_UPD;
                  end else begin
                     wr_en    = 1'b1;
                     wr_data  = acc_in;
                     pc_in    = uop.next;
                     state_in = ST_FETCH;
                  end
               end
            end
         end

         // Extended Euclid: stop when the remainder reaches zero.
         ST_EUC_CHK: begin
            if (r1_ff == '0) begin
               if (r0_ff == W'(1)) begin
                  wr_en    = 1'b1;
                  wr_data  = t0_ff;
                  pc_in    = uop.next;
                  state_in = ST_FETCH;
               end else begin
                  out_x_in   = '0;
                  out_y_in   = W'(1);
                  out_inf_in = 1'b1;
                  state_in   = ST_OUT;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_EUC_DIV;
            end
         end

         ST_EUC_DIV: begin
            if (div_done) begin
               acc_in   = '0;
               mulb_in  = div_quo;
               mcnt_in  = '0;
               phase_in = 1'b0;
               euc_in   = 1'b1;
               state_in = ST_MUL;
            end
         end

         ST_EUC_UPD: begin
            r0_in    = r1_ff;
            r1_in    = div_rem;
            t0_in    = t1_ff;
            t1_in    = alu_r;
            euc_in   = 1'b0;
            state_in = ST_EUC_CHK;
         end

         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pc_ff      <= PC_START;
         modulus_ff <= MODULUS_RESET[W-1:0];
         curve_a_ff <= CURVE_A_RESET[W-1:0];
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MODULUS: modulus_ff <= csr_wdata[W-1:0];
               CSR_CURVE_A: curve_a_ff <= csr_wdata[W-1:0];
               default:     modulus_ff <= modulus_ff;
            endcase
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (load_item) begin
         op_ff   <= req_tuser[0];
         x1_ff   <= req_tdata[W-1:0];
         y1_ff   <= req_tdata[64 +: W];
         inf1_ff <= req_tdata[128];
         x2_ff   <= req_tdata[129 +: W];
         y2_ff   <= req_tdata[193 +: W];
         inf2_ff <= req_tdata[257];
         a_ff    <= curve_a_ff;
      end else if (wr_en) begin
         unique case (wr_sel)
            R_X1:    x1_ff  <= wr_data;
            R_Y1:    y1_ff  <= wr_data;
            R_X2:    x2_ff  <= wr_data;
            R_Y2:    y2_ff  <= wr_data;
            R_A:     a_ff   <= wr_data;
            R_NUM:   num_ff <= wr_data;
            R_DEN:   den_ff <= wr_data;
            R_L:     l_ff   <= wr_data;
            R_T:     t_ff   <= wr_data;
            default: t_ff   <= t_ff;
         endcase
      end
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      t0_ff      <= t0_in;
      t1_ff      <= t1_in;
      acc_ff     <= acc_in;
      mulb_ff    <= mulb_in;
      mcnt_ff    <= mcnt_in;
      phase_ff   <= phase_in;
      euc_ff     <= euc_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_inf_ff <= out_inf_in;
   end

   // Ports.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {7'b0, out_inf_ff, DATA_BITS'(out_y_ff), DATA_BITS'(out_x_ff)};

endmodule
